/* rtl/core/sclt_pkg.sv */
// ----------------------------------------------------------------------------
// sclt_pkg: shared types and constants of the sector cache tag controller
// Request codes, field widths and the scan chain record passed cell to cell.
// ----------------------------------------------------------------------------
`default_nettype none

package sclt_pkg;

	localparam int ADDR_W = 32;
	localparam int UNIT_W = 8;
	localparam int SLOT_W = 3;

	// request function codes
	localparam logic FUNC_LOOKUP = 1'b0;
	localparam logic FUNC_FILL   = 1'b1;

	// scan record rippling from cell 0 upward
	typedef struct packed {
		logic match_seen;   // a lower cell already matched
		logic victim_seen;  // a lower cell already holds the last rank
	} scan_t;

endpackage

`default_nettype wire

/* rtl/core/sclt_cell.sv */
// ----------------------------------------------------------------------------
// sclt_cell: one cache entry of the tag controller
// Holds tag, unit, valid and recency rank; compares against the current
// request and joins the scan and pick chains to its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module sclt_cell #(
	parameter int WAYS = 6,
	parameter int IDX  = 0
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  en,
	input  wire                                  func,
	input  wire  [sclt_pkg::ADDR_W-1:0]          addr,
	input  wire  [sclt_pkg::UNIT_W-1:0]          unit,
	input  wire  sclt_pkg::scan_t                scan_in,
	output sclt_pkg::scan_t                      scan_out,
	input  wire                                  any_hit,
	input  wire  [$clog2(WAYS)-1:0]              pick_rank_in,
	output logic [$clog2(WAYS)-1:0]              pick_rank_out,
	input  wire  [$clog2(WAYS)-1:0]              pick_idx_in,
	output logic [$clog2(WAYS)-1:0]              pick_idx_out,
	input  wire  [$clog2(WAYS)-1:0]              chosen_rank
);
	import sclt_pkg::*;

	localparam int RW = $clog2(WAYS);

	logic [ADDR_W-1:0] tag_addr_q;
	logic [UNIT_W-1:0] tag_unit_q;
	logic              valid_q;
	logic [RW-1:0]     rank_q;
	logic              match;
	logic              is_last;
	logic              sel;

	assign match   = valid_q && (tag_addr_q == addr) && (tag_unit_q == unit);
	assign is_last = (rank_q == RW'(WAYS - 1));

	// hit takes the lowest matching cell; fill miss takes the least recent
	assign sel = any_hit ? (match && !scan_in.match_seen)
	                     : ((func == FUNC_FILL) && is_last && !scan_in.victim_seen);

	assign scan_out.match_seen  = scan_in.match_seen  | match;
	assign scan_out.victim_seen = scan_in.victim_seen | is_last;

	assign pick_rank_out = pick_rank_in | (sel ? rank_q : '0);
	assign pick_idx_out  = pick_idx_in  | (sel ? RW'(IDX) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= RW'(IDX);
		end else if (en) begin
			if (sel) begin
				rank_q <= '0;
				if (func == FUNC_FILL) begin
					valid_q <= 1'b1;
				end
			end else if (rank_q < chosen_rank) begin
				rank_q <= RW'(rank_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && sel && (func == FUNC_FILL)) begin
			tag_addr_q <= addr;
			tag_unit_q <= unit;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/sector_cache_lru_tags.sv */
// ----------------------------------------------------------------------------
// sector_cache_lru_tags: tag and LRU controller of a fully associative cache
// Request register feeding a row of entry cells linked by scan/pick chains.
// ----------------------------------------------------------------------------
// Usage:
//  Request channel (req_valid / req_stall) carries func, sector_address and
//  unit_number; func selects lookup or fill. Response channel
//  (rsp_valid / rsp_stall) returns hit and slot, one response per request,
//  in request order.
//  A request taken is held in the request register, then evaluated into the
//  response register, which drives the ports.
//  Throughput: one request per cycle while rsp_stall is low. The request
//  register evaluates against the entry row combinationally; tag compares
//  run in parallel in the cells and the priority pick ripples cell to cell
//  along the row. Back to back requests see the tags and ranks left by the
//  one before. Reset clears every entry's valid bit and sets entry i to
//  rank i; no entry matches until filled. No clearing pass is needed.
//  When the receiver stalls, the response register holds; the request
//  register keeps one more request, then req_stall rises until the
//  response is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sector_cache_lru_tags #(
	parameter int WAYS = 6
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              req_valid,
	output logic                             req_stall,
	input  wire                              func,
	input  wire  [sclt_pkg::ADDR_W-1:0]      sector_address,
	input  wire  [sclt_pkg::UNIT_W-1:0]      unit_number,
	output logic                             rsp_valid,
	input  wire                              rsp_stall,
	output logic                             hit,
	output logic [sclt_pkg::SLOT_W-1:0]      slot
);
	import sclt_pkg::*;

	localparam int RW = $clog2(WAYS);

	// request register
	logic              valid_s1;
	logic              func_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [UNIT_W-1:0] unit_s1;

	// response register
	logic              rsp_valid_q;
	logic              hit_q;
	logic [SLOT_W-1:0] slot_q;

	logic              advance;
	logic              accept;

	// chains through the row of cells
	scan_t             scan [WAYS+1];
	logic [RW-1:0]     pick_rank [WAYS+1];
	logic [RW-1:0]     pick_idx [WAYS+1];
	logic              any_hit;

	// the request in s1 evaluates when the response register is free or draining
	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func;
			addr_s1 <= sector_address;
			unit_s1 <= unit_number;
		end
	end

	assign scan[0]      = '0;
	assign pick_rank[0] = '0;
	assign pick_idx[0]  = '0;
	assign any_hit      = scan[WAYS].match_seen;

	for (genvar i = 0; i < WAYS; i++) begin : g_cell
		sclt_cell #(
			.WAYS (WAYS),
			.IDX  (i)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.en            (advance),
			.func          (func_s1),
			.addr          (addr_s1),
			.unit          (unit_s1),
			.scan_in       (scan[i]),
			.scan_out      (scan[i+1]),
			.any_hit       (any_hit),
			.pick_rank_in  (pick_rank[i]),
			.pick_rank_out (pick_rank[i+1]),
			.pick_idx_in   (pick_idx[i]),
			.pick_idx_out  (pick_idx[i+1]),
			.chosen_rank   (pick_rank[WAYS])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// nothing is picked on a lookup miss, so the index chain reads zero
	always_ff @(posedge clk) begin
		if (advance) begin
			hit_q  <= any_hit;
			slot_q <= SLOT_W'(pick_idx[WAYS]);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign hit       = hit_q;
	assign slot      = slot_q;

endmodule

`default_nettype wire
